>>> rtl/core/bqsa_pkg.sv
// Package for the bounded queue server admission block.
// Holds the field widths, the FIFO depth, the derived widths and the largest time value.
// No dependencies.
package bqsa_pkg;

    // FIFO storage depth, in entries
    localparam int QUEUE_DEPTH = 1024;

    // Field widths
    localparam int ARR_W   = 32;
    localparam int DUR_W   = 32;
    localparam int TIME_W  = 48;
    localparam int LIMIT_W = 10;

    // Derived widths
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int SUM_W = TIME_W + 1;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

endpackage

>>> rtl/core/bqsa_if.sv
// Valid/ready channel interfaces for job input and admission results.
// Depends on bqsa_pkg for field widths.
interface bqsa_job_if;
    import bqsa_pkg::*;

    logic             valid;
    logic             ready;
    logic [ARR_W-1:0] arrival_time;
    logic [DUR_W-1:0] duration;

    modport source (output valid, output arrival_time, output duration, input ready);
    modport sink   (input valid, input arrival_time, input duration, output ready);
endinterface

interface bqsa_res_if;
    import bqsa_pkg::*;

    logic              valid;
    logic              ready;
    logic              rejected;
    logic [TIME_W-1:0] finish_time;

    modport source (output valid, output rejected, output finish_time, input ready);
    modport sink   (input valid, input rejected, input finish_time, output ready);
endinterface

>>> rtl/core/bounded_queue_server_admission_top.sv
// A job is accepted in S_IDLE; in S_CHECK the block retires the finished entries
// for it, then registers its result once the result channel is free. It takes no new job
// until that result is registered; each stored entry is retired once. The FIFO memory
// read port (one entry per cycle, registered read data) sets the retire rate.
// Reset (synchronous, active low) clears pointers, count, newest finish time,
// queue_limit and the result valid flag; FIFO contents are never cleared.
module bounded_queue_server_admission_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bqsa_pkg::LIMIT_W-1:0] i_cfg_wdata,
    bqsa_job_if.sink                     i_job,
    bqsa_res_if.source                   o_res
);
    import bqsa_pkg::*;

    typedef enum logic {S_IDLE, S_CHECK} t_state;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // FIFO of pending finish times
    logic [TIME_W-1:0] mem [QUEUE_DEPTH];
    logic [TIME_W-1:0] r_rd_data;

    t_state            r_state,     n_state;
    logic [PTR_W-1:0]  r_head,      n_head;
    logic [PTR_W-1:0]  r_tail,      n_tail;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [TIME_W-1:0] r_last,      n_last;
    logic [LIMIT_W-1:0] r_limit,    n_limit;
    logic [ARR_W-1:0]  r_arrival,   n_arrival;
    logic [DUR_W-1:0]  r_duration,  n_duration;
    logic              r_out_valid, n_out_valid;
    logic              r_out_rej,   n_out_rej;
    logic [TIME_W-1:0] r_out_fin,   n_out_fin;

    logic              out_free;
    logic              head_hit;
    logic              reject;
    logic [TIME_W-1:0] base;
    logic [SUM_W-1:0]  sum;
    logic [TIME_W-1:0] fin;
    logic              push;
    logic              mem_we;

    // Retire test, admission test and finish time for the job in hand
    always_comb begin
        out_free = !r_out_valid || o_res.ready;
        head_hit = (r_count != '0) && (r_rd_data <= TIME_W'(r_arrival));
        reject   = (CMP_W'(r_count) > CMP_W'(r_limit))
                   || (r_count == CNT_W'(QUEUE_DEPTH));
        base     = (r_count != '0) ? r_last : TIME_W'(r_arrival);
        sum      = SUM_W'(base) + SUM_W'(r_duration);
        fin      = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        push     = (r_count == '0) || (fin != r_last);
    end

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_last      = r_last;
        n_limit     = r_limit;
        n_arrival   = r_arrival;
        n_duration  = r_duration;
        n_out_valid = r_out_valid;
        n_out_rej   = r_out_rej;
        n_out_fin   = r_out_fin;
        mem_we      = 1'b0;

        // drop the result once taken
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            n_limit = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (i_job.valid) begin
                    n_arrival  = i_job.arrival_time;
                    n_duration = i_job.duration;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (head_hit) begin
                    // retire the head entry, the read of the next one follows
                    n_head  = ptr_inc(r_head);
                    n_count = r_count - CNT_W'(1);
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rej   = reject;
                    n_out_fin   = reject ? '0 : fin;
                    if (!reject && push) begin
                        mem_we  = 1'b1;
                        n_tail  = ptr_inc(r_tail);
                        n_count = r_count + CNT_W'(1);
                        n_last  = fin;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // FIFO memory: write at tail, read the next head every cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_tail] <= fin;
        end
        r_rd_data <= mem[n_head];
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        r_arrival  <= n_arrival;
        r_duration <= n_duration;
        r_out_rej  <= n_out_rej;
        r_out_fin  <= n_out_fin;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_last      <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_last      <= n_last;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    assign i_job.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.rejected    = r_out_rej;
    assign o_res.finish_time = r_out_fin;

endmodule

>>> rtl/core/bqsa_checker.sv
// Port-level checks for the bounded queue server admission top level.
// Depends on bqsa_pkg; bound to bounded_queue_server_admission_top.
module bqsa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_rejected,
    input logic [bqsa_pkg::TIME_W-1:0] i_out_finish
);
    import bqsa_pkg::*;

    // a rejected job reports no finish time
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_rejected) |-> (i_out_finish == '0))
        else $error("rejected job with nonzero finish time");

    // one job in hand at a time: input closes after each transaction
    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a transaction");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_finish)
                                           && $stable(i_out_rejected)))
        else $error("stalled result changed");

endmodule

bind bounded_queue_server_admission_top bqsa_checker u_bqsa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_job.valid),
    .i_in_ready     (i_job.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_rejected (o_res.rejected),
    .i_out_finish   (o_res.finish_time)
);

>>> verif/testbench.sv
// Self-checking testbench for the bounded queue server admission block.
// Drives jobs and queue limits, predicts each admission result and checks it.
// Depends on bqsa_pkg, bqsa_if.sv and bounded_queue_server_admission_top.
module testbench;
    import bqsa_pkg::*;

    typedef struct packed {
        logic              rejected;
        logic [TIME_W-1:0] finish_time;
    } t_admission;

    typedef enum logic [0:0] {ROW_JOB, ROW_LIMIT} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [LIMIT_W-1:0] limit_val;
        logic [ARR_W-1:0]   arrival;
        logic [DUR_W-1:0]   duration;
        logic               known;
        t_admission         want;
    } t_stim_row;

    typedef enum logic [1:0] {STYLE_MIXED, STYLE_FILL, STYLE_HIGH} t_arrival_style;

    localparam int N_OPENING  = 16;
    localparam int N_ROWS     = 22;
    localparam int N_PHASES   = 5;
    localparam int MODE_STEP  = 520;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;

    bqsa_job_if job_if ();
    bqsa_res_if res_if ();

    bounded_queue_server_admission_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job       (job_if),
        .o_res       (res_if)
    );

    // Model state: pending finish times, newest finish time and the limit
    logic [TIME_W-1:0]  finish_model_q[$];
    logic [TIME_W-1:0]  newest_finish = '0;
    logic [LIMIT_W-1:0] queue_limit_model = '0;

    t_admission pending_admissions[$];
    t_admission head_want;
    int         mismatch_count = 0;
    int         snd_idle_pct = 33;
    int         rcv_idle_pct = 57;

    t_stim_row      stim_rows [N_ROWS];
    int unsigned    phase_items [N_PHASES];
    t_arrival_style phase_style [N_PHASES];
    logic [LIMIT_W-1:0] phase_limit [N_PHASES];

    always #6 i_clk = ~i_clk;

    // Retire finished entries, then admit or reject the job
    function automatic t_admission admit_job(input logic [ARR_W-1:0] arr,
                                             input logic [DUR_W-1:0] dur);
        t_admission        res;
        logic [TIME_W-1:0] base;
        logic [SUM_W-1:0]  sum;
        while (finish_model_q.size() > 0 && finish_model_q[0] <= TIME_W'(arr))
            void'(finish_model_q.pop_front());
        if (finish_model_q.size() > int'(queue_limit_model)
                || finish_model_q.size() >= QUEUE_DEPTH) begin
            res.rejected    = 1'b1;
            res.finish_time = '0;
        end else begin
            base = (finish_model_q.size() > 0) ? newest_finish : TIME_W'(arr);
            sum  = SUM_W'(base) + SUM_W'(dur);
            res.rejected    = 1'b0;
            res.finish_time = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
            // Equal finish times share one entry
            if (finish_model_q.size() == 0 || res.finish_time != newest_finish) begin
                finish_model_q = {finish_model_q, res.finish_time};
                newest_finish = res.finish_time;
            end
        end
        return res;
    endfunction

    // Offer one job, hold it until accepted, then record what it should give
    task automatic send_job(input logic [ARR_W-1:0] arr, input logic [DUR_W-1:0] dur,
                            input logic known, input t_admission want);
        t_admission predicted;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            job_if.valid = 1'b0;
            @(negedge i_clk);
        end
        job_if.valid        = 1'b1;
        job_if.arrival_time = arr;
        job_if.duration     = dur;
        do @(posedge i_clk); while (!job_if.ready);
        predicted = admit_job(arr, dur);
        pending_admissions = {pending_admissions, (known ? want : predicted)};
        @(negedge i_clk);
    endtask

    // Hold off until every result is back and the block has settled
    task automatic wait_drained();
        job_if.valid = 1'b0;
        while (pending_admissions.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        queue_limit_model = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_row(input t_stim_row row);
        if (row.kind == ROW_LIMIT)
            write_limit(row.limit_val);
        else
            send_job(row.arrival, row.duration, row.known, row.want);
    endtask

    // Receiver back-pressure
    always @(negedge i_clk) begin
        res_if.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_admissions.size() == 0) begin
                $display("%0t: unexpected result: rejected %0b finish %0d", $time,
                         res_if.rejected, res_if.finish_time);
                mismatch_count++;
            end else begin
                head_want = pending_admissions.pop_front();
                if (res_if.rejected !== head_want.rejected) begin
                    $display("%0t: rejected mismatch: expected %0b, got %0b", $time,
                             head_want.rejected, res_if.rejected);
                    mismatch_count++;
                end
                if (res_if.finish_time !== head_want.finish_time) begin
                    $display("%0t: finish_time mismatch: expected %0d, got %0d", $time,
                             head_want.finish_time, res_if.finish_time);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int unsigned roll;
        int unsigned step;
        int          random_sent;
        logic [32:0] arr_cursor;
        logic [DUR_W-1:0] dur;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        job_if.valid        = 1'b0;
        job_if.arrival_time = '0;
        job_if.duration     = '0;
        res_if.ready        = 1'b0;

        // Opening rows start from reset (limit 0); closing rows use the extremes.
        // A maximum arrival or duration leaves a finish time that no later arrival
        // below the maximum can retire, so those rows run after the random part.
        stim_rows = '{
            '{ROW_JOB,   10'd0,    32'd0,     32'd1,     1'b1, '{1'b0, 48'd1}},
            '{ROW_JOB,   10'd0,    32'd0,     32'd5,     1'b1, '{1'b1, 48'd0}},
            '{ROW_JOB,   10'd0,    32'd1,     32'd0,     1'b1, '{1'b0, 48'd1}},
            '{ROW_JOB,   10'd0,    32'd1,     32'd7,     1'b1, '{1'b0, 48'd8}},
            '{ROW_JOB,   10'd0,    32'd3,     32'd2,     1'b1, '{1'b1, 48'd0}},
            '{ROW_LIMIT, 10'd1023, 32'd0,     32'd0,     1'b0, '{1'b0, 48'd0}},
            '{ROW_JOB,   10'd0,    32'd3,     32'd2,     1'b1, '{1'b0, 48'd10}},
            '{ROW_JOB,   10'd0,    32'd4,     32'd0,     1'b1, '{1'b0, 48'd10}},
            '{ROW_JOB,   10'd0,    32'd2,     32'd3,     1'b1, '{1'b0, 48'd13}},
            '{ROW_JOB,   10'd0,    32'd10,    32'd1,     1'b1, '{1'b0, 48'd14}},
            '{ROW_JOB,   10'd0,    32'd100,   32'd65536, 1'b1, '{1'b0, 48'd65636}},
            '{ROW_LIMIT, 10'd1,    32'd0,     32'd0,     1'b0, '{1'b0, 48'd0}},
            '{ROW_JOB,   10'd0,    32'd200,   32'd5,     1'b1, '{1'b0, 48'd65641}},
            '{ROW_JOB,   10'd0,    32'd300,   32'd5,     1'b1, '{1'b1, 48'd0}},
            '{ROW_JOB,   10'd0,    32'd65636, 32'd9,     1'b1, '{1'b0, 48'd65650}},
            '{ROW_JOB,   10'd0,    32'd65650, 32'd1,     1'b1, '{1'b0, 48'd65651}},
            '{ROW_LIMIT, 10'd1023, 32'd0,     32'd0,     1'b0, '{1'b0, 48'd0}},
            '{ROW_JOB,   10'd0,    32'hFFFF_FFFF, 32'd0,        1'b0, '{1'b0, 48'd0}},
            '{ROW_JOB,   10'd0,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '{1'b0, 48'd0}},
            '{ROW_JOB,   10'd0,    32'd0,     32'hFFFF_FFFF, 1'b0, '{1'b0, 48'd0}},
            '{ROW_LIMIT, 10'd0,    32'd0,     32'd0,     1'b0, '{1'b0, 48'd0}},
            '{ROW_JOB,   10'd0,    32'hFFFF_FFFF, 32'd1,        1'b0, '{1'b0, 48'd0}}
        };

        phase_items = '{150, 120, 1060, 80, 150};
        phase_style = '{STYLE_MIXED, STYLE_MIXED, STYLE_FILL, STYLE_MIXED, STYLE_HIGH};
        phase_limit = '{10'd3, 10'd0, 10'd1023, LIMIT_W'($urandom_range(1, 1022)),
                        LIMIT_W'($urandom_range(0, 15))};

        // Hold the synchronous reset, then release it
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_OPENING; i++)
            run_row(stim_rows[i]);

        // Random phases, each under its own queue limit
        random_sent = 0;
        arr_cursor  = 33'd65651;
        for (int p = 0; p < N_PHASES; p++) begin
            write_limit(phase_limit[p]);
            if (phase_style[p] == STYLE_HIGH)
                arr_cursor = 33'h0_8000_0000 + 33'($urandom_range(0, 32'h7000_0000));
            for (int n = 0; n < int'(phase_items[p]); n++) begin
                // Advance the arrival time; stall it while filling the queue
                roll = $urandom_range(0, 99);
                if (phase_style[p] == STYLE_FILL) begin
                    arr_cursor = arr_cursor + (($urandom_range(0, 3) == 0) ? 33'd1 : 33'd0);
                end else if (phase_style[p] == STYLE_HIGH && roll < 5) begin
                    arr_cursor = 33'($urandom);
                end else if (roll >= 95) begin
                    step       = $urandom_range(0, 256);
                    arr_cursor = (arr_cursor > 33'(step)) ? arr_cursor - 33'(step) : 33'd0;
                end else begin
                    if (roll < 40)      step = $urandom_range(0, 3);
                    else if (roll < 75) step = $urandom_range(0, 64);
                    else if (roll < 88) step = $urandom_range(0, 1024);
                    else                step = $urandom_range(0, 65536);
                    arr_cursor = arr_cursor + 33'(step);
                end
                if (arr_cursor > 33'h0_FFFF_FFFF)
                    arr_cursor = 33'h0_FFFF_FFFF;

                roll = $urandom_range(0, 99);
                if (phase_style[p] == STYLE_FILL) dur = $urandom_range(1, 64);
                else if (roll < 5)                dur = '0;
                else if (roll < 70)               dur = $urandom_range(1, 64);
                else if (roll < 95)               dur = $urandom_range(1, 2048);
                else if (phase_style[p] == STYLE_HIGH) dur = $urandom;
                else                              dur = $urandom_range(1, 65536);

                send_job(arr_cursor[ARR_W-1:0], dur, 1'b0, '0);

                // Swap the idling of the two sides, then stop idling
                random_sent++;
                if (random_sent == MODE_STEP) begin
                    snd_idle_pct = 57;
                    rcv_idle_pct = 33;
                end else if (random_sent == 2 * MODE_STEP) begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            end
        end

        for (int i = N_OPENING; i < N_ROWS; i++)
            run_row(stim_rows[i]);

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop if results stop arriving
    initial begin
        #6000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
